/* hw/rtl/bamp_pkg.sv */
`timescale 1ns / 1ps

package bamp_pkg;

  localparam int unsigned AmpW    = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned FiltW   = 32;
  localparam int unsigned AlphaW  = 16;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [AlphaW-1:0] ALPHA_MAX_Q16 = 16'd64880;
  localparam logic [AlphaW:0]   ONE_Q16       = 17'h10000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ALPHA   = 8'd0,
    REG_DETECT  = 8'd1,
    REG_RELEASE = 8'd2,
    REG_HOLD    = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [AlphaW-1:0] alpha;
    logic [AmpW-1:0]   det_thr;
    logic [AmpW-1:0]   rel_thr;
    logic [TimeW-1:0]  hold;
  } cfg_t;

  typedef struct packed {
    logic [AmpW-1:0]  sample;
    logic [TimeW-1:0] now;
    logic             enable;
  } item_t;

  typedef struct packed {
    logic             confirming;
    logic [TimeW-1:0] elapsed;
    logic             detected;
  } det_status_t;

endpackage

/* hw/rtl/bamp_filter.sv */
`timescale 1ns / 1ps

module bamp_filter import bamp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [AmpW-1:0]   sample,
  input  logic [AlphaW-1:0] alpha,
  output logic [FiltW-1:0]  filt_next
);

  logic             loaded;
  logic [FiltW-1:0] filt_value;

  logic [AlphaW+FiltW-1:0] old_term;
  logic [AlphaW+FiltW-1:0] old_rnd;
  logic [AlphaW+AmpW:0]    new_term;
  logic [FiltW-1:0]        blend;

  // low half of the new-sample term is zero, so it adds after the shift
  always_comb begin
    old_term  = (AlphaW+FiltW)'(alpha) * (AlphaW+FiltW)'(filt_value);
    old_rnd   = old_term + (AlphaW+FiltW)'(32'd32768);
    new_term  = (AlphaW+AmpW+1)'(ONE_Q16 - {1'b0, alpha}) * (AlphaW+AmpW+1)'(sample);
    blend     = old_rnd[AlphaW+FiltW-1:16] + new_term[FiltW-1:0];
    filt_next = loaded ? blend : {sample, 16'h0000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded     <= 1'b0;
      filt_value <= '0;
    end else if (advance) begin
      loaded     <= 1'b1;
      filt_value <= filt_next;
    end
  end

endmodule

/* hw/rtl/bamp_detector.sv */
`timescale 1ns / 1ps

module bamp_detector import bamp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [FiltW-1:0] filt_next,
  input  logic [TimeW-1:0] now,
  input  logic             enable,
  input  cfg_t             cfg,
  output det_status_t      status_next
);

  logic             active;
  logic [TimeW-1:0] start;
  logic [TimeW-1:0] progress;
  logic             flag;

  logic             active_next;
  logic [TimeW-1:0] start_next;
  logic [TimeW-1:0] progress_next;
  logic             flag_next;
  logic             hit;
  logic             low;
  logic [TimeW-1:0] diff;

  always_comb begin
    active_next   = active;
    start_next    = start;
    progress_next = progress;
    flag_next     = flag;
    hit  = filt_next >= {cfg.det_thr, 16'h0000};
    low  = filt_next <= {cfg.rel_thr, 16'h0000};
    diff = '0;
    if (!enable) begin
      active_next   = 1'b0;
      start_next    = '0;
      progress_next = '0;
      flag_next     = 1'b0;
    end else begin
      priority if (hit) begin
        if (!active) begin
          active_next   = 1'b1;
          start_next    = now;
          progress_next = '0;
        end
      end else if (low) begin
        active_next   = 1'b0;
        start_next    = '0;
        progress_next = '0;
        flag_next     = 1'b0;
      end else begin
        // between thresholds only the running timer moves
      end
      if (active_next) begin
        // clock going backwards counts as no time
        diff = (now >= start_next) ? (now - start_next) : '0;
        if (diff >= cfg.hold) begin
          progress_next = cfg.hold;
          flag_next     = 1'b1;
        end else begin
          progress_next = diff;
        end
      end
    end
    status_next.confirming = active_next;
    status_next.elapsed    = progress_next;
    status_next.detected   = flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      start    <= '0;
      progress <= '0;
      flag     <= 1'b0;
    end else if (advance) begin
      active   <= active_next;
      start    <= start_next;
      progress <= progress_next;
      flag     <= flag_next;
    end
  end

endmodule

/* hw/rtl/beacon_amplitude_detector_unit.sv */
`timescale 1ns / 1ps

// channel  dir  handshake                     payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata: sample, time; tuser: enable
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: echo, smoothed, elapsed; tuser: flags
// cfg      in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// one word per cycle unless the output stalls; each word is registered at the input, then in the output register
// rate set by the filter multiply-accumulate feeding the detector combinationally in the same cycle
// rst clears the filter, detector state, config registers and both valids
// a stalled result holds in the output register; input stage keeps taking
// words while the output register is empty or being drained

module beacon_amplitude_detector_unit import bamp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [47:0]        s_axis_tdata,   // sample_amplitude, time_now_ms
  input  logic [0:0]         s_axis_tuser,   // detect_enable
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [79:0]        m_axis_tdata,   // echo_amplitude, smoothed_amplitude,
                                             // confirm_elapsed_ms
  output logic [1:0]         m_axis_tuser,   // confirming, detected
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t        cfg;
  item_t       item;
  logic        item_valid;
  logic        advance;
  logic [FiltW-1:0] filt_next;
  det_status_t status_next;

  logic [AmpW-1:0]  out_echo;
  logic [FiltW-1:0] out_filt;
  det_status_t      out_status;
  logic             out_valid;

  assign cfg_ready     = 1'b1;
  assign advance       = item_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ALPHA: begin
          cfg.alpha <= (cfg_data[AlphaW-1:0] > ALPHA_MAX_Q16) ? ALPHA_MAX_Q16
                                                              : cfg_data[AlphaW-1:0];
        end
        REG_DETECT:  cfg.det_thr <= cfg_data[AmpW-1:0];
        REG_RELEASE: cfg.rel_thr <= cfg_data[AmpW-1:0];
        REG_HOLD:    cfg.hold    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      item.sample <= s_axis_tdata[15:0];
      item.now    <= s_axis_tdata[47:16];
      item.enable <= s_axis_tuser[0];
    end
  end

  bamp_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .sample    (item.sample),
    .alpha     (cfg.alpha),
    .filt_next (filt_next)
  );

  bamp_detector u_detector (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .filt_next   (filt_next),
    .now         (item.now),
    .enable      (item.enable),
    .cfg         (cfg),
    .status_next (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_echo   <= item.sample;
      out_filt   <= filt_next;
      out_status <= status_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_status.elapsed, out_filt, out_echo};
  assign m_axis_tuser  = {out_status.detected, out_status.confirming};

  a_detect_needs_confirm: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status.detected |-> out_status.confirming)
    else $error("detected without confirmation");

  a_idle_elapsed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_status.confirming |-> out_status.elapsed == '0)
    else $error("elapsed time without confirmation");

  a_smoothed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_filt[15:0] == 16'h0000 || out_filt[31:16] != 16'hFFFF)
    else $error("smoothed amplitude out of range");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced word lost");

endmodule

/* bench/tb_beacon_amplitude_detector_unit.sv */
`timescale 1ns / 1ps

module tb_beacon_amplitude_detector_unit;
  import bamp_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned PressureHold = 400;
  localparam logic [CfgIdxW-1:0] REG_SPARE = 8'hA5;

  typedef enum int unsigned {
    LVL_HIGH,
    LVL_LOW,
    LVL_MID
  } level_t;

  typedef struct {
    logic [AmpW-1:0]  echo;
    logic [FiltW-1:0] smoothed;
    bit               confirming;
    logic [TimeW-1:0] elapsed;
    bit               detected;
  } amp_report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [47:0]        s_axis_tdata = '0;
  logic [0:0]         s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [79:0]        m_axis_tdata;
  logic [1:0]         m_axis_tuser;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  beacon_amplitude_detector_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // predictor state and register copies
  logic [AlphaW-1:0] cfg_alpha = '0;
  logic [AmpW-1:0]   cfg_det = '0;
  logic [AmpW-1:0]   cfg_rel = '0;
  logic [TimeW-1:0]  cfg_hold = '0;
  bit                filt_loaded = 1'b0;
  logic [FiltW-1:0]  filt_q = '0;
  bit                conf_on = 1'b0;
  logic [TimeW-1:0]  conf_start = '0;
  logic [TimeW-1:0]  conf_ms = '0;
  bit                det_on = 1'b0;

  amp_report_t pending_reports[$];

  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned stall_left = 0;
  int unsigned rx_roll;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  bit          hold_pending = 1'b0;
  logic [TimeW-1:0] stamp_ms = '0;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_left == 0 && hold_pending) begin
        hold_pending = 1'b0;
        stall_left = PressureHold;
      end else if (stall_left == 0 && !rx_steady) begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 12) begin
          stall_left = $urandom_range(1, 3);
        end else if (rx_roll < 15) begin
          stall_left = $urandom_range(10, 30);
        end
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    amp_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result word with no expectation waiting");
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (m_axis_tdata[15:0] !== want.echo) begin
          $error("echo_amplitude: expected %0h, got %0h", want.echo, m_axis_tdata[15:0]);
          fail_count++;
        end
        if (m_axis_tdata[47:16] !== want.smoothed) begin
          $error("smoothed_amplitude: expected %0h, got %0h", want.smoothed,
                 m_axis_tdata[47:16]);
          fail_count++;
        end
        if (m_axis_tdata[79:48] !== want.elapsed) begin
          $error("confirm_elapsed_ms: expected %0h, got %0h", want.elapsed,
                 m_axis_tdata[79:48]);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.confirming) begin
          $error("confirming: expected %0b, got %0b", want.confirming, m_axis_tuser[0]);
          fail_count++;
        end
        if (m_axis_tuser[1] !== want.detected) begin
          $error("detected: expected %0b, got %0b", want.detected, m_axis_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  function automatic amp_report_t step_detector(input logic [AmpW-1:0] amp,
                                                input logic [TimeW-1:0] stamp,
                                                input bit en);
    logic [63:0] weight;
    logic [63:0] acc;
    amp_report_t rep;
    if (!filt_loaded) begin
      filt_q = {amp, 16'h0};
      filt_loaded = 1'b1;
    end else begin
      weight = (cfg_alpha > ALPHA_MAX_Q16) ? {48'h0, ALPHA_MAX_Q16} : {48'h0, cfg_alpha};
      acc = weight * {32'h0, filt_q}
          + ({47'h0, ONE_Q16} - weight) * {32'h0, amp, 16'h0}
          + 64'd32768;
      filt_q = acc[47:16];
    end
    if (!en) begin
      conf_on = 1'b0;
      conf_start = '0;
      conf_ms = '0;
      det_on = 1'b0;
    end else begin
      if (filt_q >= {cfg_det, 16'h0}) begin
        if (!conf_on) begin
          conf_on = 1'b1;
          conf_start = stamp;
          conf_ms = '0;
        end
      end else if (filt_q <= {cfg_rel, 16'h0}) begin
        conf_on = 1'b0;
        conf_start = '0;
        conf_ms = '0;
        det_on = 1'b0;
      end
      if (conf_on) begin
        conf_ms = (stamp >= conf_start) ? stamp - conf_start : '0;
        if (conf_ms >= cfg_hold) begin
          conf_ms = cfg_hold;
          det_on = 1'b1;
        end
      end
    end
    rep.echo = amp;
    rep.smoothed = filt_q;
    rep.confirming = conf_on;
    rep.elapsed = conf_ms;
    rep.detected = det_on;
    return rep;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // valid stays high after a word is taken so back-to-back words need no gap
  task automatic send_word(input logic [AmpW-1:0] amp, input logic [TimeW-1:0] stamp,
                           input bit en);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {stamp, amp};
    s_axis_tuser <= en;
    do @(posedge clk); while (!s_axis_tready);
    pending_reports.push_back(step_detector(amp, stamp, en));
    words_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (cfg_reg_t'(idx))
      REG_ALPHA:   cfg_alpha = value[15:0];
      REG_DETECT:  cfg_det = value[15:0];
      REG_RELEASE: cfg_rel = value[15:0];
      REG_HOLD:    cfg_hold = value;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [15:0] alpha, input logic [15:0] det,
                             input logic [15:0] rel, input logic [31:0] hold);
    write_reg(REG_ALPHA, {16'h0, alpha});
    write_reg(REG_DETECT, {16'h0, det});
    write_reg(REG_RELEASE, {16'h0, rel});
    write_reg(REG_HOLD, hold);
  endtask

  // first word loads the filter; reset thresholds and zero hold detect at once
  task automatic test_first_load();
    send_word(16'hFFFF, 32'h0, 1'b1);
    send_word(16'h0000, 32'hFFFF_FFFF, 1'b1);
    settle();
  endtask

  // alpha above the clamp, threshold extremes, ignored spare register
  task automatic test_extremes();
    load_config(16'hFFFF, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    write_reg(REG_SPARE, 32'h0000_1234);
    send_word(16'hFFFF, 32'h0, 1'b1);
    send_word(16'hFFFF, 32'h8000_0000, 1'b1);
    send_word(16'h0000, 32'h7FFF_FFFF, 1'b0);
    send_word(16'h5555, 32'h5555_5555, 1'b1);
    settle();
    load_config(16'h0000, 16'hFFFF, 16'hFFFF, 32'h0);
    send_word(16'hFFFF, 32'hAAAA_AAAA, 1'b1);
    send_word(16'hAAAA, 32'h0000_0001, 1'b1);
    settle();
  endtask

  // start, between thresholds, saturate, clock going back, release, disable
  task automatic test_hysteresis();
    load_config(16'h0000, 16'd1000, 16'd500, 32'd50);
    send_word(16'd1200, 32'd100, 1'b1);
    send_word(16'd800, 32'd120, 1'b1);
    send_word(16'd1100, 32'd160, 1'b1);
    send_word(16'd700, 32'd170, 1'b1);
    send_word(16'd1000, 32'd5, 1'b1);
    send_word(16'd400, 32'd200, 1'b1);
    send_word(16'd2000, 32'd210, 1'b1);
    send_word(16'd2000, 32'd300, 1'b0);
    settle();
  endtask

  // release above detect: the detect compare wins
  task automatic test_release_above_detect();
    load_config(16'h8000, 16'd1000, 16'd3000, 32'd10);
    send_word(16'd2000, 32'd1000, 1'b1);
    send_word(16'd2000, 32'd1020, 1'b1);
    send_word(16'd100, 32'd1030, 1'b1);
    send_word(16'd100, 32'd1040, 1'b1);
    settle();
  endtask

  task automatic run_episodes(input int unsigned count);
    level_t           level;
    int unsigned      level_left;
    logic [AmpW-1:0]  amp;
    logic [AmpW-1:0]  lo;
    logic [AmpW-1:0]  hi;
    logic [TimeW-1:0] step_max;
    int unsigned      r;
    bit               en;
    level_left = 0;
    level = LVL_LOW;
    lo = (cfg_det < cfg_rel) ? cfg_det : cfg_rel;
    hi = (cfg_det < cfg_rel) ? cfg_rel : cfg_det;
    step_max = (cfg_hold > 32'd100000) ? 32'd20000 : cfg_hold / 4 + 2;
    for (int unsigned n = 0; n < count; n++) begin
      if (level_left == 0) begin
        level = level_t'($urandom_range(0, 2));
        level_left = (cfg_alpha > 16'd60000) ? $urandom_range(20, 120) : $urandom_range(3, 20);
      end
      level_left--;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_word(16'($urandom), $urandom, 1'($urandom));
      end else begin
        if (r < 8) begin
          stamp_ms = stamp_ms - $urandom_range(1, 500);
        end else begin
          stamp_ms = stamp_ms + $urandom_range(0, step_max);
        end
        case (level)
          LVL_HIGH: amp = 16'($urandom_range(cfg_det, 16'hFFFF));
          LVL_LOW:  amp = 16'($urandom_range(0, cfg_rel));
          default:  amp = 16'($urandom_range(lo, hi));
        endcase
        en = ($urandom_range(0, 99) >= 4);
        send_word(amp, stamp_ms, en);
      end
    end
  endtask

  // receiver holds off while the sender keeps offering words back to back
  task automatic test_backpressure();
    load_config(16'h4000, 16'd20000, 16'd10000, 32'd30);
    tx_steady = 1'b1;
    hold_pending = 1'b1;
    run_episodes(60);
    tx_steady = 1'b0;
    settle();
  endtask

  task automatic test_random_phases();
    logic [15:0] alpha;
    logic [15:0] det;
    logic [15:0] rel;
    logic [31:0] hold;
    for (int unsigned p = 0; p < 8; p++) begin
      alpha = 16'($urandom);
      det = 16'($urandom_range(0, 16'hFFFF));
      rel = 16'($urandom_range(0, det));
      hold = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 300);
      case (p)
        0: begin alpha = 16'h0000; hold = 32'h0; end
        1: begin alpha = 16'hFFFF; hold = 32'hFFFF_FFFF; end
        2: alpha = ALPHA_MAX_Q16;
        3: alpha = ALPHA_MAX_Q16 + 16'd1;
        4: begin det = 16'h0000; rel = 16'hFFFF; end
        5: begin det = 16'hFFFF; rel = 16'hFFFF; end
        6: rel = 16'($urandom_range(det, 16'hFFFF));
        default: ;
      endcase
      load_config(alpha, det, rel, hold);
      tx_steady = (p % 3 == 1);
      rx_steady = (p % 4 == 2);
      run_episodes(215);
      settle();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_load();
    test_extremes();
    test_hysteresis();
    test_release_above_detect();
    test_backpressure();
    test_random_phases();
    settle();
    repeat (10) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected results never arrived", pending_reports.size());
      fail_count++;
    end
    $display("sent %0d sample words across %0d register writes", words_sent, reg_writes);
    $display("checked %0d results, including a long output stall", reports_checked);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bamp_pkg.sv
hw/rtl/bamp_filter.sv
hw/rtl/bamp_detector.sv
hw/rtl/beacon_amplitude_detector_unit.sv
bench/tb_beacon_amplitude_detector_unit.sv
